FILE: rtl/gda_pkg.sv
// Package for the Gregorian date-plus-days unit.
// Holds the calendar constants and the control struct of the year residue unit.
// No dependencies.
`default_nettype none

package gda_pkg;

	// Width of a year field and the last year that may be represented.
	localparam int YEAR_WIDTH = 14;
	localparam int MAX_YEAR = 9999;

	// The leap-year pattern repeats every 400 years.
	localparam int CYCLE_YEARS = 400;
	localparam int R400_WIDTH = $clog2(CYCLE_YEARS);

	// Default width of the day count.
	localparam int DAYS_WIDTH_DEF = 16;

	// Commands to the year residue unit.
	typedef struct packed {
		logic load;   // take a new year and reduce it modulo 400
		logic inc;    // the year advanced by one
	} r400_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/gregorian_date_add_days_unit.sv
// Channel  | Signals                                              | Handshake
// ---------+------------------------------------------------------+----------------------
// command  | start_day, start_month, start_year, days_to_add      | start, taken when !busy
// result   | status, result_day, result_month, result_year        | done, one-cycle strobe
//
// An item is reduced modulo 400, its day checked, then walked one month at a time;
// the month walk through the subtract-and-compare step dominates. An invalid month or
// year is answered in the cycle after accept.
// Reset clears the sequencer and the strobe; the result cannot be stalled.
// Top level of the Gregorian date-plus-days unit; depends on gda_pkg, gda_r400, gda_cal.
`default_nettype none

module gregorian_date_add_days_unit #(
	parameter int DAYS_WIDTH = gda_pkg::DAYS_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [4:0]                         start_day,
	input  wire logic [3:0]                         start_month,
	input  wire logic [gda_pkg::YEAR_WIDTH-1:0]     start_year,
	input  wire logic [DAYS_WIDTH-1:0]              days_to_add,
	output logic                                    done,
	output logic [1:0]                              status,
	output logic [4:0]                              result_day,
	output logic [3:0]                              result_month,
	output logic [gda_pkg::YEAR_WIDTH-1:0]          result_year
);
	import gda_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_REDUCE = 3'd1;
	localparam logic [2:0] ST_CHECK  = 3'd2;
	localparam logic [2:0] ST_WALK   = 3'd3;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_INVALID  = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;

	localparam logic [YEAR_WIDTH-1:0] LAST_YEAR = YEAR_WIDTH'(MAX_YEAR);

	logic [2:0]              state_q;
	logic [4:0]              day_q;
	logic [3:0]              month_q;
	logic [YEAR_WIDTH-1:0]   year_q;
	logic [DAYS_WIDTH-1:0]   left_days_q;

	r400_ctl_t               r400_ctl;
	logic                    r400_ready;
	logic [R400_WIDTH-1:0]   r400;
	logic [4:0]              month_len;
	logic [4:0]              rest;
	logic [DAYS_WIDTH-1:0]   rest_ext;
	logic                    accept;
	logic                    bad_head;

	gda_r400 u_r400 (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (r400_ctl),
		.year    (start_year),
		.ready   (r400_ready),
		.residue (r400)
	);

	gda_cal u_cal (
		.month     (month_q),
		.residue   (r400),
		.month_len (month_len)
	);

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Month and year range checks that need no calendar lookup.
	assign bad_head = (start_month == 4'd0) || (start_month > 4'd12) ||
		(start_year == '0) || (start_year > LAST_YEAR);

	// Days remaining in the current month after the current day.
	assign rest = month_len - day_q;
	assign rest_ext = DAYS_WIDTH'(rest);

	// Residue unit commands: load on accept, step when the walk wraps a year.
	always_comb begin
		r400_ctl.load = accept;
		r400_ctl.inc = (state_q == ST_WALK) && (left_days_q > rest_ext) &&
			(month_q == 4'd12);
	end

	// Sequencer state and the done strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (bad_head) begin
							done <= 1'b1;
						end else begin
							state_q <= ST_REDUCE;
						end
					end
				end
				ST_REDUCE: begin
					if (r400_ready) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (day_q == 5'd0 || day_q > month_len) begin
						done <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (left_days_q <= rest_ext) begin
						done <= 1'b1;
						state_q <= ST_IDLE;
					end else if (month_q == 4'd12 && year_q == LAST_YEAR) begin
						done <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working date and the count of days still to add.
	always_ff @(posedge clk) begin
		if (accept) begin
			day_q <= start_day;
			month_q <= start_month;
			year_q <= start_year;
			left_days_q <= days_to_add;
		end else if (state_q == ST_WALK && left_days_q > rest_ext) begin
			left_days_q <= left_days_q - rest_ext - 1'b1;
			day_q <= 5'd1;
			if (month_q == 4'd12) begin
				month_q <= 4'd1;
				year_q <= year_q + 1'b1;
			end else begin
				month_q <= month_q + 1'b1;
			end
		end
	end

	// Result registers, written in the cycle that finishes an item.
	always_ff @(posedge clk) begin
		if (accept && bad_head) begin
			status <= STAT_INVALID;
			result_day <= '0;
			result_month <= '0;
			result_year <= '0;
		end else if (state_q == ST_CHECK && (day_q == 5'd0 || day_q > month_len)) begin
			status <= STAT_INVALID;
			result_day <= '0;
			result_month <= '0;
			result_year <= '0;
		end else if (state_q == ST_WALK) begin
			if (left_days_q <= rest_ext) begin
				status <= STAT_OK;
				result_day <= day_q + left_days_q[4:0];
				result_month <= month_q;
				result_year <= year_q;
			end else if (month_q == 4'd12 && year_q == LAST_YEAR) begin
				status <= STAT_OVERFLOW;
				result_day <= '0;
				result_month <= '0;
				result_year <= '0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/gda_r400.sv
// Year residue unit: keeps the current year modulo 400.
// A load reduces the year by repeated subtraction, one step per cycle.
// Depends on gda_pkg.
`default_nettype none

module gda_r400 (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire gda_pkg::r400_ctl_t                   ctl,
	input  wire logic [gda_pkg::YEAR_WIDTH-1:0]       year,
	output logic                                      ready,
	output logic [gda_pkg::R400_WIDTH-1:0]            residue
);
	import gda_pkg::*;

	localparam logic [YEAR_WIDTH-1:0] CYCLE_Y = YEAR_WIDTH'(CYCLE_YEARS);
	localparam logic [YEAR_WIDTH-1:0] LAST_R = YEAR_WIDTH'(CYCLE_YEARS - 1);

	logic [YEAR_WIDTH-1:0] rem_q;

	// The subtractor takes 400 off while the residue is still too large.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (ctl.load) begin
			rem_q <= year;
		end else if (rem_q >= CYCLE_Y) begin
			rem_q <= rem_q - CYCLE_Y;
		end else if (ctl.inc) begin
			rem_q <= (rem_q == LAST_R) ? '0 : rem_q + 1'b1;
		end
	end

	assign ready = (rem_q < CYCLE_Y);
	assign residue = rem_q[R400_WIDTH-1:0];

endmodule

`default_nettype wire

FILE: rtl/gda_cal.sv
// Month length lookup for the Gregorian calendar.
// Uses the year modulo 400 to decide leap years.
// Depends on gda_pkg.
`default_nettype none

module gda_cal (
	input  wire logic [3:0]                    month,
	input  wire logic [gda_pkg::R400_WIDTH-1:0] residue,
	output logic [4:0]                          month_len
);
	import gda_pkg::*;

	logic leap;

	// Divisible by 4 and not a century, or a multiple of 400.
	always_comb begin
		leap = (residue[1:0] == 2'b00) &&
			!(residue == R400_WIDTH'(100) || residue == R400_WIDTH'(200) ||
			  residue == R400_WIDTH'(300));
	end

	// Days in the month; codes outside 1 to 12 are never asked for.
	always_comb begin
		case (month)
			4'd2: month_len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
			default: month_len = 5'd31;
		endcase
	end

endmodule

`default_nettype wire

FILE: bench/gda_add_days_checker.sv
`timescale 1ns / 100ps
// Result checker for the Gregorian date-plus-days unit: predicts each result and compares it.
// Depends on gda_pkg for the year width, the default day-count width and the last representable year.

module gda_add_days_checker #(
	parameter int DAYS_WIDTH = gda_pkg::DAYS_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic [4:0]                      start_day,
	input  logic [3:0]                      start_month,
	input  logic [gda_pkg::YEAR_WIDTH-1:0]  start_year,
	input  logic [DAYS_WIDTH-1:0]           days_to_add,
	input  logic                            done,
	input  logic [1:0]                      status,
	input  logic [4:0]                      result_day,
	input  logic [3:0]                      result_month,
	input  logic [gda_pkg::YEAR_WIDTH-1:0]  result_year,
	output int                              fail_count,
	output int                              pending_dates
);

	typedef enum logic [1:0] {
		DATE_OK       = 2'd0,
		DATE_INVALID  = 2'd1,
		YEAR_OVERFLOW = 2'd2
	} add_status_e;

	typedef struct packed {
		add_status_e                    status;
		logic [4:0]                     day;
		logic [3:0]                     month;
		logic [gda_pkg::YEAR_WIDTH-1:0] year;
	} later_date_t;

	// Results still owed by the unit, oldest first.
	later_date_t expected_dates[$];

	function automatic bit is_leap(input int unsigned year);
		return (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
	endfunction

	function automatic int unsigned days_in_month(input int unsigned month,
			input int unsigned year);
		if (month == 2)
			return is_leap(year) ? 29 : 28;
		if (month == 4 || month == 6 || month == 9 || month == 11)
			return 30;
		return 31;
	endfunction

	// Validates the start date, then walks forward a month at a time.
	function automatic later_date_t calc_later_date(input logic [4:0] d_in,
			input logic [3:0] m_in, input logic [gda_pkg::YEAR_WIDTH-1:0] y_in,
			input logic [DAYS_WIDTH-1:0] n_in);
		int unsigned d;
		int unsigned m;
		int unsigned y;
		int unsigned left;
		longint unsigned n;
		later_date_t r;
		d = 32'(d_in);
		m = 32'(m_in);
		y = 32'(y_in);
		n = 64'(n_in);
		r.status = DATE_OK;
		if (m < 1 || m > 12 || y < 1 || y > gda_pkg::MAX_YEAR ||
				d < 1 || d > days_in_month(m, y)) begin
			r.status = DATE_INVALID;
		end else begin
			while (n > 0 && r.status == DATE_OK) begin
				left = days_in_month(m, y) - d;
				if (n <= left) begin
					d = d + 32'(n);
					n = 0;
				end else begin
					// Jump to the first of the next month.
					n = n - (left + 1);
					d = 1;
					m = m + 1;
					if (m > 12) begin
						m = 1;
						y = y + 1;
						if (y > gda_pkg::MAX_YEAR)
							r.status = YEAR_OVERFLOW;
					end
				end
			end
		end
		if (r.status != DATE_OK) begin
			d = 0;
			m = 0;
			y = 0;
		end
		r.day = d[4:0];
		r.month = m[3:0];
		r.year = y[gda_pkg::YEAR_WIDTH-1:0];
		return r;
	endfunction

	// Compare each strobed result with the oldest prediction, then record new items.
	always @(posedge clk or negedge arst_n) begin
		later_date_t exp_date;
		if (!arst_n) begin
			expected_dates.delete();
			fail_count = 0;
			pending_dates = 0;
		end else begin
			if (done) begin
				if (expected_dates.size() == 0) begin
					$error("result strobe with no item outstanding");
					fail_count++;
				end else begin
					exp_date = expected_dates.pop_front();
					if (status !== exp_date.status) begin
						$error("status: expected %0d, got %0d", exp_date.status, status);
						fail_count++;
					end
					if (result_day !== exp_date.day) begin
						$error("result_day: expected %0d, got %0d", exp_date.day, result_day);
						fail_count++;
					end
					if (result_month !== exp_date.month) begin
						$error("result_month: expected %0d, got %0d", exp_date.month,
							result_month);
						fail_count++;
					end
					if (result_year !== exp_date.year) begin
						$error("result_year: expected %0d, got %0d", exp_date.year,
							result_year);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				expected_dates.push_back(calc_later_date(start_day, start_month,
					start_year, days_to_add));
			pending_dates = expected_dates.size();
		end
	end

endmodule

FILE: bench/gregorian_date_add_days_unit_test.sv
`timescale 1ns / 100ps
// Top of the testbench for the Gregorian date-plus-days unit: reset, stimulus and verdict.
// Depends on gda_pkg, the unit itself and gda_add_days_checker.

module gregorian_date_add_days_unit_test;

	localparam int DAYS_WIDTH = gda_pkg::DAYS_WIDTH_DEF;
	localparam int YW = gda_pkg::YEAR_WIDTH;
	// Watchdog limit: the longest item plus a sender gap, with a wide margin.
	localparam int STALL_LIMIT = 12000;
	localparam int TAIL_CYCLES = 2300;
	localparam int ITEMS_PER_PHASE = 82;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [4:0] start_day;
	logic [3:0] start_month;
	logic [YW-1:0] start_year;
	logic [DAYS_WIDTH-1:0] days_to_add;
	logic done;
	logic [1:0] status;
	logic [4:0] result_day;
	logic [3:0] result_month;
	logic [YW-1:0] result_year;

	int fail_count;
	int pending_dates;
	int idle_pct;
	int stall_cycles;

	gregorian_date_add_days_unit #(
		.DAYS_WIDTH(DAYS_WIDTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.start_day(start_day),
		.start_month(start_month),
		.start_year(start_year),
		.days_to_add(days_to_add),
		.done(done),
		.status(status),
		.result_day(result_day),
		.result_month(result_month),
		.result_year(result_year)
	);

	gda_add_days_checker #(
		.DAYS_WIDTH(DAYS_WIDTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.start_day(start_day),
		.start_month(start_month),
		.start_year(start_year),
		.days_to_add(days_to_add),
		.done(done),
		.status(status),
		.result_day(result_day),
		.result_month(result_month),
		.result_year(result_year),
		.fail_count(fail_count),
		.pending_dates(pending_dates)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: give up when neither an item nor a result moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("[gregorian_date_add_days_unit] ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Offer one item, after an occasional random gap, and hold it until the unit takes it.
	// Called and returns at a falling edge.
	task automatic send_date(input logic [4:0] d, input logic [3:0] m,
			input logic [YW-1:0] y, input logic [DAYS_WIDTH-1:0] n);
		int gap;
		gap = 0;
		if ($urandom_range(99) < idle_pct)
			gap = ($urandom_range(9) == 0) ? $urandom_range(8, 60) : $urandom_range(1, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		start_day <= d;
		start_month <= m;
		start_year <= y;
		days_to_add <= n;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	// Stop sending until every outstanding result has come back.
	task automatic drain_results();
		start <= 1'b0;
		while (pending_dates != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	// Random items: mostly plausible dates with mixed day counts, some raw noise.
	task automatic send_random_dates(input int count);
		logic [4:0] d;
		logic [3:0] m;
		logic [YW-1:0] y;
		logic [DAYS_WIDTH-1:0] n;
		int pick;
		repeat (count) begin
			if ($urandom_range(99) < 20) begin
				d = 5'($urandom_range(31));
				m = 4'($urandom_range(15));
				y = YW'($urandom_range((1 << YW) - 1));
			end else begin
				m = 4'($urandom_range(1, 12));
				d = ($urandom_range(99) < 70) ? 5'($urandom_range(1, 28)) :
					5'($urandom_range(29, 31));
				pick = $urandom_range(99);
				if (pick < 15)
					y = YW'($urandom_range(9800, gda_pkg::MAX_YEAR));
				else if (pick < 25)
					y = YW'($urandom_range(1, 99) * 100);
				else
					y = YW'($urandom_range(1, gda_pkg::MAX_YEAR));
			end
			// Keep most walks short; a few use the whole day range.
			pick = $urandom_range(99);
			if (pick < 65)
				n = DAYS_WIDTH'($urandom_range(400));
			else if (pick < 90)
				n = DAYS_WIDTH'($urandom_range(5000));
			else
				n = DAYS_WIDTH'($urandom_range((1 << DAYS_WIDTH) - 1));
			send_date(d, m, y, n);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		start_day = '0;
		start_month = '0;
		start_year = '0;
		days_to_add = '0;
		idle_pct = 28;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed items: the worked example, leap rules, bounds and bad dates.
		send_date(5'd30, 4'd12, 14'd2015, 16'd16);
		send_date(5'd1, 4'd1, 14'd1, 16'd0);
		send_date(5'd31, 4'd12, 14'd9999, 16'd0);
		send_date(5'd31, 4'd12, 14'd9999, 16'd1);
		send_date(5'd29, 4'd2, 14'd2000, 16'd365);
		send_date(5'd29, 4'd2, 14'd1900, 16'd1);
		send_date(5'd29, 4'd2, 14'd2024, 16'd1);
		send_date(5'd28, 4'd2, 14'd2023, 16'd1);
		send_date(5'd0, 4'd5, 14'd2020, 16'd10);
		send_date(5'd31, 4'd4, 14'd2020, 16'd3);
		send_date(5'd15, 4'd0, 14'd2020, 16'd3);
		send_date(5'd15, 4'd13, 14'd2020, 16'd3);
		send_date(5'd15, 4'd15, 14'd2020, 16'd3);
		send_date(5'd1, 4'd1, 14'd0, 16'd3);
		send_date(5'd1, 4'd1, 14'd10000, 16'd3);
		send_date(5'd31, 4'd7, 14'd16383, 16'd3);
		send_date(5'd31, 4'd1, 14'd2020, 16'hFFFF);
		send_date(5'd1, 4'd1, 14'd9821, 16'hFFFF);
		send_date(5'd1, 4'd1, 14'd1, 16'hFFFF);
		send_date(5'd31, 4'd15, 14'd16383, 16'hFFFF);
		send_date(5'd31, 4'd12, 14'd1999, 16'd1);
		send_date(5'd30, 4'd11, 14'd2021, 16'd31);
		send_date(5'd1, 4'd3, 14'd9999, 16'd305);
		send_date(5'd1, 4'd3, 14'd9999, 16'd306);
		send_date(5'd0, 4'd0, 14'd0, 16'd0);

		// Random phases: sender idles often, then more, then never.
		send_random_dates(ITEMS_PER_PHASE);
		drain_results();
		idle_pct = 64;
		send_random_dates(ITEMS_PER_PHASE);
		drain_results();
		idle_pct = 0;
		send_random_dates(ITEMS_PER_PHASE);
		drain_results();

		// Watch for stray strobes before the verdict.
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("[gregorian_date_add_days_unit] OK");
		else
			$display("[gregorian_date_add_days_unit] ERROR");
		$finish;
	end

endmodule

FILE: sim.f
rtl/gda_pkg.sv
rtl/gda_r400.sv
rtl/gda_cal.sv
rtl/gregorian_date_add_days_unit.sv
bench/gda_add_days_checker.sv
bench/gregorian_date_add_days_unit_test.sv
